@@ design/wdr_pkg.sv @@
// ----------------------------------------------------------------------------
// wdr_pkg
// Shared types, codes and lookup functions for the watchdog refresh countdown.
// ----------------------------------------------------------------------------
package wdr_pkg;

  localparam int unsigned CountW     = 14;
  localparam int unsigned PrescaleW  = 13;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 3;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 24;

  localparam logic [ByteW-1:0] SeqFirst  = 8'h00;
  localparam logic [ByteW-1:0] SeqSecond = 8'hFF;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [CfgAddrW-1:0] {
    REG_TIMEOUT    = 2'd0,
    REG_PRESCALE   = 2'd1,
    REG_RESET_MODE = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_addr_t;

  typedef struct packed {
    logic [1:0] timeout_sel;
    logic [2:0] prescale_sel;
    logic       reset_mode;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0]    down_count;
    logic [PrescaleW-1:0] prescale_count;
    logic                 running;
    logic                 armed;
    logic                 underflow;
  } wdt_state_t;

  typedef struct packed {
    logic                 nmi_request;
    logic                 reset_request;
    logic                 underflow_seen;
    logic                 counting;
    logic [CountW-1:0]    count_value;
  } result_t;

  // reload value for each timeout code
  function automatic logic [CountW-1:0] reload_value(input logic [1:0] sel);
    logic [CountW-1:0] v;
    case (sel)
      2'd0:    v = 14'd255;
      2'd1:    v = 14'd1023;
      2'd2:    v = 14'd4095;
      default: v = 14'd16383;
    endcase
    return v;
  endfunction

  // last prescaler value before a count step (divider minus one)
  function automatic logic [PrescaleW-1:0] prescale_last(input logic [2:0] sel);
    logic [PrescaleW-1:0] v;
    case (sel)
      3'd0:    v = 13'd3;
      3'd1:    v = 13'd63;
      3'd2:    v = 13'd127;
      3'd3:    v = 13'd511;
      3'd4:    v = 13'd2047;
      default: v = 13'd8191;
    endcase
    return v;
  endfunction

endpackage

@@ design/wdr_step.sv @@
// ----------------------------------------------------------------------------
// wdr_step
// Next-state and result logic for one request against the watchdog state.
// ----------------------------------------------------------------------------
module wdr_step
  import wdr_pkg::*;
(
  input  wdt_state_t       state,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  input  logic [ByteW-1:0] write_byte,
  output wdt_state_t       state_next,
  output result_t          result
);

  logic wrap;
  logic fire;

  assign wrap = state.prescale_count >= prescale_last(cfg.prescale_sel);
  assign fire = (cmd == CMD_TICK) && state.running && wrap
                && (state.down_count == '0);

  always_comb begin
    state_next = state;
    case (cmd)
      CMD_TICK: begin
        if (state.running) begin
          if (wrap) begin
            state_next.prescale_count = '0;
            if (state.down_count == '0) begin
              state_next.running   = 1'b0;
              state_next.underflow = 1'b1;
            end else begin
              state_next.down_count = state.down_count - 1'b1;
            end
          end else begin
            state_next.prescale_count = state.prescale_count + 1'b1;
          end
        end
      end
      CMD_REFRESH: begin
        if (state.armed && (write_byte == SeqSecond)) begin
          state_next.down_count     = reload_value(cfg.timeout_sel);
          state_next.prescale_count = '0;
          state_next.running        = 1'b1;
          state_next.armed          = 1'b0;
        end else begin
          state_next.armed = (write_byte == SeqFirst);
        end
      end
      CMD_CLEAR: begin
        state_next.underflow = 1'b0;
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  always_comb begin
    result.count_value    = state_next.down_count;
    result.counting       = state_next.running;
    result.underflow_seen = state_next.underflow;
    result.reset_request  = fire && cfg.reset_mode;
    result.nmi_request    = fire && !cfg.reset_mode;
  end

endmodule

@@ design/watchdog_refresh_countdown.sv @@
// ----------------------------------------------------------------------------
// watchdog_refresh_countdown
// Watchdog down-counter with a 0x00 / 0xFF refresh sequence and prescaler.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the command (tick, refresh
// write, status clear), s_tdata the byte for a refresh write. Every request
// gives exactly one result on the m_ stream: count value, running flag,
// sticky underflow flag and a one-result reset or nmi request pulse.
// A request is registered in the input register when it is accepted, applied
// to the counter state by the update logic and loaded into the result
// register together with the new state once the result register is free.
// One request is taken every cycle while the result side does not stall; the
// rate is set by the single update pass between input and result registers.
// When m_tready is low the result register holds and the input register takes
// one more request, then s_tready drops until the result is taken.
// The cfg port writes timeout, prescale and reset/nmi selection; write only
// while no request is in flight. Reset clears the counter (stopped), the
// refresh sequence and the flag, and restores timeout 16384, divide by 8192
// and reset mode.
// ----------------------------------------------------------------------------
module watchdog_refresh_countdown
  import wdr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [7:0] write_byte
  input  logic [InUserW-1:0]  s_tuser,   // [1:0] cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  // [13:0] count_value, [14] counting, [15] underflow_seen,
  // [16] reset_request, [17] nmi_request, [23:18] zero
  output logic [OutDataW-1:0] m_tdata
);

  cfg_t             cfg;
  wdt_state_t       state;
  wdt_state_t       state_next;
  result_t          step_result;
  result_t          out_result;
  logic             in_valid;
  cmd_t             in_cmd;
  logic [ByteW-1:0] in_byte;
  logic             out_valid;
  logic             advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_sel  <= 2'd3;
      cfg.prescale_sel <= 3'd5;
      cfg.reset_mode   <= 1'b1;
    end else if (cfg_wr_en) begin
      case (reg_addr_t'(cfg_addr))
        REG_TIMEOUT:    cfg.timeout_sel  <= cfg_wdata[1:0];
        REG_PRESCALE:   cfg.prescale_sel <= cfg_wdata[2:0];
        REG_RESET_MODE: cfg.reset_mode   <= cfg_wdata[0];
        default:        cfg              <= cfg;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= cmd_t'(s_tuser);
      in_byte <= s_tdata[ByteW-1:0];
    end
  end

  wdr_step u_step (
    .state      (state),
    .cfg        (cfg),
    .cmd        (in_cmd),
    .write_byte (in_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  // watchdog state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_result};

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.reset_request && out_result.nmi_request))
    else $error("reset and nmi request in the same result");

  a_request_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result.reset_request || out_result.nmi_request)) |->
      (out_result.underflow_seen && !out_result.counting
       && (out_result.count_value == '0)))
    else $error("request pulse without underflow state");

  a_stopped_on_fire: assert property (@(posedge clk) disable iff (rst)
    (advance && (step_result.reset_request || step_result.nmi_request)) |=>
      (!state.running && (state.prescale_count == '0)))
    else $error("counter still running after underflow");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a full pipeline");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the watchdog refresh countdown. A directed set of
// requests covers the idle block, the 0x00 / 0xFF refresh sequence and its
// broken forms. Random phases then run the counter under several timeout,
// prescale and reset/nmi settings, one of them letting the counter run out. Each
// result is checked against an in-bench counter model or a typed expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import wdr_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned NumDirected = 20;
  localparam int unsigned NumPhases   = 9;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wbyte;
    logic       typed;
    result_t    want;
  } dir_row_t;

  typedef struct packed {
    logic [2:0]  tsel;
    logic [2:0]  psel;
    logic        mode;
    int unsigned items;
    int unsigned seq_pct;
    int unsigned noise_pct;
    logic        kick;
    logic        hold;
    logic        calm;
  } phase_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  // model of the counter and its registers
  logic [13:0] wd_count;
  logic [12:0] wd_prescale;
  logic        wd_running;
  logic        wd_armed;
  logic        wd_flag;
  logic [1:0]  sel_timeout;
  logic [2:0]  sel_prescale;
  logic        sel_reset_mode;

  result_t     pending_results[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned cycle_count;
  bit          hold_req;
  bit          calm;

  dir_row_t    dir_rows[NumDirected];
  phase_t      plan[NumPhases];

  watchdog_refresh_countdown DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic result_t make_result(input logic [13:0] cnt, input logic run,
                                          input logic uf, input logic rq, input logic nmi);
    result_t r;
    r.count_value    = cnt;
    r.counting       = run;
    r.underflow_seen = uf;
    r.reset_request  = rq;
    r.nmi_request    = nmi;
    return r;
  endfunction

  function automatic logic [13:0] timeout_reload(input logic [1:0] sel);
    case (sel)
      2'd0:    return 14'd255;
      2'd1:    return 14'd1023;
      2'd2:    return 14'd4095;
      default: return 14'd16383;
    endcase
  endfunction

  // codes above divide-by-8192 saturate
  function automatic logic [12:0] divider_last(input logic [2:0] sel);
    case (sel)
      3'd0:    return 13'd3;
      3'd1:    return 13'd63;
      3'd2:    return 13'd127;
      3'd3:    return 13'd511;
      3'd4:    return 13'd2047;
      default: return 13'd8191;
    endcase
  endfunction

  task automatic predict_request(input cmd_t c, input logic [7:0] b, output result_t r);
    logic rq;
    logic nmi;
    rq  = 1'b0;
    nmi = 1'b0;
    case (c)
      CMD_TICK: begin
        if (wd_running) begin
          if (wd_prescale >= divider_last(sel_prescale)) begin
            wd_prescale = '0;
            if (wd_count == 0) begin
              wd_running = 1'b0;
              wd_flag    = 1'b1;
              if (sel_reset_mode) rq = 1'b1;
              else nmi = 1'b1;
            end else begin
              wd_count = wd_count - 14'd1;
            end
          end else begin
            wd_prescale = wd_prescale + 13'd1;
          end
        end
      end
      CMD_REFRESH: begin
        if (wd_armed && b == SeqSecond) begin
          wd_count    = timeout_reload(sel_timeout);
          wd_prescale = '0;
          wd_running  = 1'b1;
          wd_armed    = 1'b0;
        end else begin
          wd_armed = (b == SeqFirst);
        end
      end
      CMD_CLEAR: wd_flag = 1'b0;
      default: ;
    endcase
    r = make_result(wd_count, wd_running, wd_flag, rq, nmi);
  endtask

  task automatic send_request(input cmd_t c, input logic [7:0] b, input logic typed,
                              input result_t want);
    result_t r;
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom);
      s_tuser  = 2'($urandom);
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = c;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(c, b, r);
    pending_results.push_back(typed ? want : r);
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input reg_addr_t a, input logic [2:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr  = a;
    cfg_wdata = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_addr  = 2'($urandom);
    cfg_wdata = 3'($urandom);
    case (a)
      REG_TIMEOUT:    sel_timeout    = v[1:0];
      REG_PRESCALE:   sel_prescale   = v;
      REG_RESET_MODE: sel_reset_mode = v[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input phase_t ph);
    int unsigned start;
    int unsigned pick;
    cmd_t        c;
    logic [7:0]  b;
    start = requests_sent;
    hold_req = ph.hold;
    if (ph.kick) begin
      send_request(CMD_REFRESH, SeqFirst, 1'b0, '0);
      send_request(CMD_REFRESH, SeqSecond, 1'b0, '0);
    end
    while (requests_sent - start < ph.items) begin
      pick = $urandom_range(0, 99);
      if (pick < ph.seq_pct) begin
        send_request(CMD_REFRESH, SeqFirst, 1'b0, '0);
        // ticks and clears in between must not break the sequence
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            c = $urandom_range(0, 1) ? CMD_TICK : ($urandom_range(0, 1) ? CMD_CLEAR : CMD_NOP);
            send_request(c, 8'($urandom), 1'b0, '0);
          end
        end
        b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : SeqSecond;
        send_request(CMD_REFRESH, b, 1'b0, '0);
      end else if (pick < ph.seq_pct + ph.noise_pct) begin
        case ($urandom_range(0, 3))
          0: begin
            case ($urandom_range(0, 2))
              0:       b = SeqFirst;
              1:       b = SeqSecond;
              default: b = 8'($urandom);
            endcase
            send_request(CMD_REFRESH, b, 1'b0, '0);
          end
          1, 2:    send_request(CMD_CLEAR, 8'($urandom), 1'b0, '0);
          default: send_request(CMD_NOP, 8'($urandom), 1'b0, '0);
        endcase
      end else begin
        send_request(CMD_TICK, 8'($urandom), 1'b0, '0);
      end
    end
    wait_idle();
  endtask

  // result side: random stall bursts plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[17:0];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, got %h", $time, m_tdata);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.count_value !== exp_r.count_value) begin
          $display("%0t count_value: expected %0d, got %0d", $time,
                   exp_r.count_value, got.count_value);
          mismatches++;
        end
        if (got.counting !== exp_r.counting) begin
          $display("%0t counting: expected %b, got %b", $time, exp_r.counting, got.counting);
          mismatches++;
        end
        if (got.underflow_seen !== exp_r.underflow_seen) begin
          $display("%0t underflow_seen: expected %b, got %b", $time,
                   exp_r.underflow_seen, got.underflow_seen);
          mismatches++;
        end
        if (got.reset_request !== exp_r.reset_request) begin
          $display("%0t reset_request: expected %b, got %b", $time,
                   exp_r.reset_request, got.reset_request);
          mismatches++;
        end
        if (got.nmi_request !== exp_r.nmi_request) begin
          $display("%0t nmi_request: expected %b, got %b", $time,
                   exp_r.nmi_request, got.nmi_request);
          mismatches++;
        end
        if (m_tdata[23:18] !== 6'd0) begin
          $display("%0t padding: expected 0, got %h", $time, m_tdata[23:18]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    result_t idle_r;
    result_t full_r;
    idle_r = make_result(14'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    full_r = make_result(14'd16383, 1'b1, 1'b0, 1'b0, 1'b0);

    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_addr       = '0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    hold_req       = 1'b0;
    calm           = 1'b0;
    mismatches     = 0;
    requests_sent  = 0;
    cycle_count    = 0;
    wd_count       = '0;
    wd_prescale    = '0;
    wd_running     = 1'b0;
    wd_armed       = 1'b0;
    wd_flag        = 1'b0;
    sel_timeout    = 2'd3;
    sel_prescale   = 3'd5;
    sel_reset_mode = 1'b1;

    // stopped block, broken and valid refresh sequences, reset settings
    dir_rows[0]  = '{CMD_TICK,    8'h00, 1'b1, idle_r};
    dir_rows[1]  = '{CMD_NOP,     8'hFF, 1'b1, idle_r};
    dir_rows[2]  = '{CMD_CLEAR,   8'hAA, 1'b1, idle_r};
    dir_rows[3]  = '{CMD_REFRESH, 8'hFF, 1'b1, idle_r};
    dir_rows[4]  = '{CMD_REFRESH, 8'h00, 1'b1, idle_r};
    dir_rows[5]  = '{CMD_REFRESH, 8'h55, 1'b1, idle_r};
    dir_rows[6]  = '{CMD_REFRESH, 8'hFF, 1'b1, idle_r};
    dir_rows[7]  = '{CMD_REFRESH, 8'h00, 1'b1, idle_r};
    dir_rows[8]  = '{CMD_REFRESH, 8'h00, 1'b1, idle_r};
    dir_rows[9]  = '{CMD_REFRESH, 8'hFF, 1'b1, full_r};
    dir_rows[10] = '{CMD_TICK,    8'h5A, 1'b0, '0};
    dir_rows[11] = '{CMD_REFRESH, 8'h00, 1'b0, '0};
    dir_rows[12] = '{CMD_TICK,    8'hFF, 1'b0, '0};
    dir_rows[13] = '{CMD_CLEAR,   8'h00, 1'b0, '0};
    dir_rows[14] = '{CMD_NOP,     8'h00, 1'b0, '0};
    dir_rows[15] = '{CMD_REFRESH, 8'hFF, 1'b1, full_r};
    dir_rows[16] = '{CMD_REFRESH, 8'hAA, 1'b0, '0};
    dir_rows[17] = '{CMD_REFRESH, 8'hFF, 1'b0, '0};
    dir_rows[18] = '{CMD_TICK,    8'h01, 1'b0, '0};
    dir_rows[19] = '{CMD_CLEAR,   8'h80, 1'b0, '0};

    // the run-out phase ticks only, so the counter surely underflows;
    // the short phase after a divide-by-8192 run lowers the divider mid-count
    plan[0] = '{3'd3, 3'd5, 1'b1,   40, 4, 9, 1'b0, 1'b0, 1'b0};
    plan[1] = '{3'd0, 3'd0, 1'b1, 1040, 0, 0, 1'b1, 1'b0, 1'b0};
    plan[2] = '{3'd1, 3'd1, 1'b0,   40, 4, 9, 1'b0, 1'b1, 1'b0};
    plan[3] = '{3'd3, 3'd5, 1'b0,   20, 0, 9, 1'b1, 1'b0, 1'b0};
    plan[4] = '{3'd0, 3'd0, 1'b0,   10, 0, 9, 1'b0, 1'b0, 1'b0};
    plan[5] = '{3'd0, 3'd0, 1'b0,   20, 0, 3, 1'b1, 1'b0, 1'b0};
    plan[6] = '{3'd2, 3'd6, 1'b1,   20, 5, 9, 1'b1, 1'b0, 1'b0};
    plan[7] = '{3'd1, 3'd7, 1'b0,   20, 5, 9, 1'b0, 1'b0, 1'b0};
    plan[8] = '{3'd0, 3'd2, 1'b1,   30, 6, 9, 1'b1, 1'b0, 1'b1};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NumDirected; i++) begin
      send_request(dir_rows[i].cmd, dir_rows[i].wbyte, dir_rows[i].typed, dir_rows[i].want);
    end
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p == 6) write_register(REG_UNUSED, 3'($urandom));
      write_register(REG_TIMEOUT, {1'($urandom), plan[p].tsel[1:0]});
      write_register(REG_PRESCALE, plan[p].psel);
      write_register(REG_RESET_MODE, {2'($urandom), plan[p].mode});
      calm = plan[p].calm;
      run_phase(plan[p]);
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/wdr_pkg.sv
design/wdr_step.sv
design/watchdog_refresh_countdown.sv
tb/tb_top.sv
